// File: hdl/lfs_pkg.sv
package lfs_pkg;

  localparam int SENSORS    = 5;
  localparam int SAMPLE_W   = 8;
  localparam int CAL_ROUNDS = 50;
  localparam int ROUND_W    = 6;

  typedef enum logic [2:0] {
    DIR_LEFT       = 3'd0,
    DIR_HARD_LEFT  = 3'd1,
    DIR_FORWARD    = 3'd2,
    DIR_HARD_RIGHT = 3'd3,
    DIR_RIGHT      = 3'd4,
    DIR_BRAKE      = 3'd5
  } dir_t;

  // line patterns, bit 4 is the leftmost sensor
  localparam logic [SENSORS-1:0] PAT_CENTER      = 5'h04;
  localparam logic [SENSORS-1:0] PAT_CENTER_WIDE = 5'h0E;
  localparam logic [SENSORS-1:0] PAT_ALL         = 5'h1F;
  localparam logic [SENSORS-1:0] PAT_LEFT_PAIR   = 5'h0C;
  localparam logic [SENSORS-1:0] PAT_LEFT_ONE    = 5'h08;
  localparam logic [SENSORS-1:0] PAT_RIGHT_ONE   = 5'h02;
  localparam logic [SENSORS-1:0] PAT_RIGHT_PAIR  = 5'h06;
  localparam logic [SENSORS-1:0] PAT_EDGE_L      = 5'h10;
  localparam logic [SENSORS-1:0] PAT_EDGE_L2     = 5'h18;
  localparam logic [SENSORS-1:0] PAT_EDGE_L3     = 5'h1C;
  localparam logic [SENSORS-1:0] PAT_EDGE_R      = 5'h01;
  localparam logic [SENSORS-1:0] PAT_EDGE_R2     = 5'h03;
  localparam logic [SENSORS-1:0] PAT_EDGE_R3     = 5'h07;

  // calibration control shared by all lanes
  typedef struct packed {
    logic active;  // this set is a calibration set
    logic last;    // this set is the final calibration set
  } cal_ctrl_t;

  typedef struct packed {
    dir_t               dir;
    logic [SENSORS-1:0] bits;
    logic [3:0]         motor;  // left_a, left_b, right_a, right_b
    logic               cal;
  } result_t;

  typedef struct packed {
    logic known;
    dir_t dir;
  } decode_t;

  function automatic logic [3:0] motor_bits(input dir_t d);
    logic [3:0] m;
    m = 4'b0000;
    unique case (d)
      DIR_LEFT:       m = 4'b0010;
      DIR_HARD_LEFT:  m = 4'b0110;
      DIR_FORWARD:    m = 4'b1010;
      DIR_HARD_RIGHT: m = 4'b1001;
      DIR_RIGHT:      m = 4'b1000;
      default:        m = 4'b0000;
    endcase
    return m;
  endfunction

  function automatic decode_t decode_pattern(input logic [SENSORS-1:0] p);
    decode_t r;
    r.known = 1'b1;
    r.dir   = DIR_FORWARD;
    unique case (p) inside
      PAT_CENTER, PAT_CENTER_WIDE, PAT_ALL:   r.dir = DIR_FORWARD;
      PAT_LEFT_PAIR, PAT_LEFT_ONE:            r.dir = DIR_LEFT;
      PAT_RIGHT_ONE, PAT_RIGHT_PAIR:          r.dir = DIR_RIGHT;
      PAT_EDGE_L, PAT_EDGE_L2, PAT_EDGE_L3:   r.dir = DIR_HARD_LEFT;
      PAT_EDGE_R, PAT_EDGE_R2, PAT_EDGE_R3:   r.dir = DIR_HARD_RIGHT;
      default:                                r.known = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/line_follower_steering_core.sv
// each result is registered into the output queue at its input transfer
// throughput: one sample set per cycle unless stalled; sensor lanes merge combinationally
// a two-entry output queue keeps input transfers going while a result waits
// reset (synchronous, active high): calibration restarts, min 255 / max 0 / trip 0,
// last direction forward, output queue empty
module line_follower_steering_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lfs_pkg::SAMPLE_W-1:0] sample_0,
  input  logic [lfs_pkg::SAMPLE_W-1:0] sample_1,
  input  logic [lfs_pkg::SAMPLE_W-1:0] sample_2,
  input  logic [lfs_pkg::SAMPLE_W-1:0] sample_3,
  input  logic [lfs_pkg::SAMPLE_W-1:0] sample_4,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   direction,
  output logic [lfs_pkg::SENSORS-1:0]  line_bits,
  output logic                         left_motor_a,
  output logic                         left_motor_b,
  output logic                         right_motor_a,
  output logic                         right_motor_b,
  output logic                         calibrating
);
  import lfs_pkg::*;

  logic                take;
  logic                q_full;
  cal_ctrl_t           ctrl;
  logic [SAMPLE_W-1:0] samples [SENSORS];
  logic [SENSORS-1:0]  pattern;
  result_t             result, head;

  // input transfer whenever the output queue has room
  assign in_stall = q_full;
  assign take     = in_valid && !in_stall;

  assign samples[0] = sample_0;
  assign samples[1] = sample_1;
  assign samples[2] = sample_2;
  assign samples[3] = sample_3;
  assign samples[4] = sample_4;

  // one lane per sensor: min/max tracking, midpoint and threshold compare
  for (genvar i = 0; i < SENSORS; i++) begin : g_lane
    lfs_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .take   (take),
      .ctrl   (ctrl),
      .sample (samples[i]),
      .hit    (pattern[SENSORS-1-i])  // leftmost sensor lands in the msb
    );
  end

  // merge: calibration count, pattern decode, last direction, motor bits
  lfs_steer u_steer (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .pattern (pattern),
    .ctrl    (ctrl),
    .result  (result)
  );

  lfs_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_data (result),
    .pop_stall (out_stall),
    .full      (q_full),
    .valid     (out_valid),
    .head      (head)
  );

  assign direction     = head.dir;
  assign line_bits     = head.bits;
  assign left_motor_a  = head.motor[3];
  assign left_motor_b  = head.motor[2];
  assign right_motor_a = head.motor[1];
  assign right_motor_b = head.motor[0];
  assign calibrating   = head.cal;

`ifndef SYNTH
  // calibration results always brake with an empty pattern
  a_cal_brake: assert property (@(posedge clk) disable iff (rst)
    (out_valid && calibrating) |-> (direction == DIR_BRAKE && line_bits == '0))
    else $error("calibration result is not a brake");

  // brake only ever shows up during calibration
  a_brake_cal: assert property (@(posedge clk) disable iff (rst)
    (out_valid && direction == DIR_BRAKE) |-> calibrating)
    else $error("brake outside calibration");

  // an input transfer always leaves a result behind
  a_xfer_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("input transfer produced no result");

  // input is held off only while results are queued
  a_stall_queued: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with an empty queue");
`endif

endmodule

// File: hdl/lfs_lane.sv
module lfs_lane (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         take,
  input  lfs_pkg::cal_ctrl_t           ctrl,
  input  logic [lfs_pkg::SAMPLE_W-1:0] sample,
  output logic                         hit
);
  import lfs_pkg::*;

  logic [SAMPLE_W-1:0] low_seen, high_seen, trip_point;
  logic [SAMPLE_W-1:0] low_next, high_next, span, trip_next;

  always_comb begin
    low_next  = (sample < low_seen) ? sample : low_seen;
    high_next = (sample > high_seen) ? sample : high_seen;
    span      = high_next - low_next;
    // midpoint, low when the range is inverted
    trip_next = (high_next >= low_next) ? (low_next + (span >> 1)) : low_next;
  end

  assign hit = (sample >= trip_point);

  always_ff @(posedge clk) begin
    if (rst) begin
      low_seen   <= '1;
      high_seen  <= '0;
      trip_point <= '0;
    end else if (take && ctrl.active) begin
      low_seen  <= low_next;
      high_seen <= high_next;
      if (ctrl.last) begin
        trip_point <= trip_next;
      end
    end
  end

endmodule

// File: hdl/lfs_steer.sv
module lfs_steer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  input  logic [lfs_pkg::SENSORS-1:0] pattern,
  output lfs_pkg::cal_ctrl_t          ctrl,
  output lfs_pkg::result_t            result
);
  import lfs_pkg::*;

  logic [ROUND_W-1:0] round_count;
  dir_t               last_dir;
  decode_t            dec;
  dir_t               dir_sel;

  assign ctrl.active = (round_count < ROUND_W'(CAL_ROUNDS));
  assign ctrl.last   = (round_count == ROUND_W'(CAL_ROUNDS - 1));

  always_comb begin
    dec     = decode_pattern(pattern);
    dir_sel = dec.known ? dec.dir : last_dir;
    if (ctrl.active) begin
      result.dir   = DIR_BRAKE;
      result.bits  = '0;
      result.motor = motor_bits(DIR_BRAKE);
      result.cal   = 1'b1;
    end else begin
      result.dir   = dir_sel;
      result.bits  = pattern;
      result.motor = motor_bits(dir_sel);
      result.cal   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      round_count <= '0;
      last_dir    <= DIR_FORWARD;
    end else if (take) begin
      if (ctrl.active) begin
        round_count <= round_count + ROUND_W'(1);
      end else if (dec.known) begin
        last_dir <= dec.dir;
      end
    end
  end

endmodule

// File: hdl/lfs_outq.sv
module lfs_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lfs_pkg::result_t push_data,
  input  logic             pop_stall,
  output logic             full,
  output logic             valid,
  output lfs_pkg::result_t head
);
  import lfs_pkg::*;

  result_t    q [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign valid = (count != 2'd0);
  assign full  = (count == 2'd2);
  assign pop   = valid && !pop_stall;
  assign head  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
